// ----- design/sis_pkg.sv -----
package sis_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int VALUE_W      = 64;
	localparam int COUNT_W      = 9;

	// opcodes
	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]                opcode;
		logic signed [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// per-cycle commands broadcast along the cell row
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

// ----- design/sorted_integer_set_unit.sv -----
// Sorted set of distinct signed 64-bit integers.
// Request channel req_valid / req_stall / req carries an opcode (find,
// insert, remove) and a value; response channel rsp_valid / rsp_stall / rsp
// returns one word per request: a status (done, present-or-absent, full)
// and the number of values held afterwards.
// The values live in a row of CAPACITY cells, kept in ascending order.
// A request passes a compare state and then an update state: in the first
// every cell compares its entry with the value, in the second the row shifts
// up (insert) or down (remove) from the matching place in one step. The
// response is registered and appears the cycle after the update. A new
// request is taken in the update cycle of the previous one, so the unit can
// take a request before the previous response has left.
// If the receiver stalls, the response word holds; one further request may
// be taken and compared, and its update waits until the held word leaves.
// Reset empties the set (count to zero) and drops rsp_valid; the response
// word and the cell contents are not cleared and are never read until written.
module sorted_integer_set_unit
	import sis_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]          count_q;
	logic [1:0]                op_q;
	logic signed [VALUE_W-1:0] key_q;
	logic                      rsp_valid_q;
	rsp_word_t                 rsp_q;

	logic [CAPACITY-1:0]       occ;
	logic [CAPACITY-1:0]       less;
	logic [CAPACITY-1:0]       eq;
	logic signed [VALUE_W-1:0] vals [CAPACITY];

	cell_ctl_t ctl;
	logic      accept;
	logic      upd_go;
	logic      held;
	logic      full;
	logic      do_ins;
	logic      do_rem;
	logic [1:0] status;

	assign upd_go = (state_q == ST_UPD) && (!rsp_valid_q || !rsp_stall);
	assign accept = req_valid && !req_stall;
	assign held   = |eq;
	assign full   = (count_q == CNT_W'(CAPACITY));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (upd_go) state_d = accept ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		ctl       = '0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		status    = STAT_MISS;
		unique case (op_q)
			OP_FIND: begin
				status = held ? STAT_OK : STAT_MISS;
			end
			OP_INSERT: begin
				if (held) begin
					status = STAT_MISS;
				end else if (full) begin
					status = STAT_FULL;
				end else begin
					status = STAT_OK;
					do_ins = upd_go;
				end
			end
			OP_REMOVE: begin
				status = held ? STAT_OK : STAT_MISS;
				do_rem = upd_go && held;
			end
			default: begin
				status = STAT_MISS;
			end
		endcase
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_CMP:  ctl.cmp   = 1'b1;
			ST_UPD: begin
				req_stall = !upd_go;
				ctl.ins   = do_ins;
				ctl.rem   = do_rem;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.value;
		end
		if (upd_go) begin
			rsp_q.status <= status;
			if (do_ins) begin
				rsp_q.count <= COUNT_W'(count_q + CNT_W'(1));
			end else if (do_rem) begin
				rsp_q.count <= COUNT_W'(count_q - CNT_W'(1));
			end else begin
				rsp_q.count <= COUNT_W'(count_q);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
		logic                      left_less;
		logic signed [VALUE_W-1:0] left_val;
		logic signed [VALUE_W-1:0] right_val;

		assign occ[gi] = IDX < count_q;

		if (gi == 0) begin : g_first
			assign left_less = 1'b1;
			assign left_val  = key_q;
		end else begin : g_mid
			assign left_less = less[gi-1];
			assign left_val  = vals[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_last
			assign right_val = vals[gi];
		end else begin : g_inner
			assign right_val = vals[gi+1];
		end

		sis_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ[gi]),
			.key       (key_q),
			.left_less (left_less),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (vals[gi]),
			.less      (less[gi]),
			.eq        (eq[gi])
		);
	end

endmodule

// ----- design/sis_cell.sv -----
module sis_cell
	import sis_pkg::*;
(
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic                      occ,
	input  logic signed [VALUE_W-1:0] key,
	input  logic                      left_less,
	input  logic signed [VALUE_W-1:0] left_val,
	input  logic signed [VALUE_W-1:0] right_val,
	output logic signed [VALUE_W-1:0] val,
	output logic                      less,
	output logic                      eq
);

	logic signed [VALUE_W-1:0] val_q;
	logic                      less_s1;
	logic                      eq_s1;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			less_s1 <= occ && (val_q < key);
			eq_s1   <= occ && (val_q == key);
		end
		// entries below the key stay; the rest shift up or down by one
		if (ctl.ins && !less_s1) begin
			val_q <= left_less ? key : left_val;
		end else if (ctl.rem && !less_s1) begin
			val_q <= right_val;
		end
	end

	assign val  = val_q;
	assign less = less_s1;
	assign eq   = eq_s1;

endmodule

// ----- design/sisu_checker.sv -----
module sisu_checker
	import sis_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_word_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

	// held response word must not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// one request in the compare step at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken in the compare cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 511) || (rsp.count <= CAP_CNT))
		else $error("count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_FULL) |-> rsp.count == CAP_CNT)
		else $error("full reported below capacity");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == STAT_OK || rsp.status == STAT_MISS ||
			rsp.status == STAT_FULL)
		else $error("undefined status code");

endmodule

bind sorted_integer_set_unit sisu_checker #(.CAPACITY(CAPACITY)) u_sisu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- verif/tb_sorted_integer_set_unit.sv -----
module tb_sorted_integer_set_unit;
	import sis_pkg::*;

	localparam int SET_CAP     = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 24;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// predicted contents of the set, ascending
	logic signed [VALUE_W-1:0] held_vals [SET_CAP];
	int                        held_count;
	rsp_word_t                 rsp_due [$];
	logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;
	int err_count;
	int cycle_count;

	sorted_integer_set_unit #(
		.CAPACITY(SET_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// apply one word to the predicted set and return the answer it earns
	function automatic rsp_word_t set_apply(req_word_t w);
		rsp_word_t r;
		int        pos;
		bit        held;
		pos = 0;
		while (pos < held_count && held_vals[pos] < $signed(w.value))
			pos++;
		held = (pos < held_count) && (held_vals[pos] == $signed(w.value));
		r.status = STAT_MISS;
		case (w.opcode)
			OP_FIND: begin
				if (held)
					r.status = STAT_OK;
			end
			OP_INSERT: begin
				// presence wins over full
				if (held) begin
					r.status = STAT_MISS;
				end else if (held_count >= SET_CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (int k = held_count; k > pos; k--)
						held_vals[k] = held_vals[k-1];
					held_vals[pos] = w.value;
					held_count++;
					r.status = STAT_OK;
				end
			end
			OP_REMOVE: begin
				if (held) begin
					for (int k = pos; k + 1 < held_count; k++)
						held_vals[k] = held_vals[k+1];
					held_count--;
					r.status = STAT_OK;
				end
			end
			default: begin
			end
		endcase
		r.count = held_count[COUNT_W-1:0];
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] val);
		req_word_t w;
		w.opcode = op;
		w.value  = val;
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_valid = 1'b1;
		req       = w;
		do
			@(posedge clk);
		while (req_stall);
		rsp_due.push_back(set_apply(w));
		@(negedge clk);
	endtask

	task automatic wait_drained;
		req_valid = 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else begin
			rsp_stall = ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected word: status %0d count %0d", rsp.status, rsp.count);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status || rsp.count !== want.count) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: expected status %0d count %0d, got status %0d count %0d",
							want.status, want.count, rsp.status, rsp.count);
				end
			end
		end
	end

	task automatic test_empty_store;
		send_word(OP_FIND, '0);
		send_word(OP_REMOVE, VAL_MIN);
		send_word(OP_UNUSED, '0);
		send_word(OP_FIND, VAL_MAX);
		send_word(OP_REMOVE, -64'sd1);
	endtask

	task automatic test_extremes;
		send_word(OP_INSERT, VAL_MIN);
		send_word(OP_INSERT, VAL_MAX);
		send_word(OP_INSERT, '0);
		send_word(OP_INSERT, -64'sd1);
		send_word(OP_INSERT, 64'sd1);
		send_word(OP_INSERT, VAL_MIN);
		send_word(OP_FIND, VAL_MAX);
		send_word(OP_FIND, -64'sd1);
		send_word(OP_FIND, 64'sd2);
		send_word(OP_UNUSED, VAL_MAX);
		send_word(OP_REMOVE, VAL_MAX);
		send_word(OP_REMOVE, VAL_MAX);
		send_word(OP_REMOVE, VAL_MIN);
		send_word(OP_FIND, VAL_MIN);
		send_word(OP_INSERT, 64'sh5555_5555_5555_5555);
		send_word(OP_INSERT, 64'shAAAA_AAAA_AAAA_AAAA);
		send_word(OP_FIND, 64'shAAAA_AAAA_AAAA_AAAA);
	endtask

	task automatic test_fill_to_full;
		// long receiver hold while inserts keep coming, so the request side backs up
		hold_left = 120;
		while (held_count < SET_CAP)
			send_word(OP_INSERT, {$urandom, $urandom});
		send_word(OP_INSERT, held_vals[$urandom_range(SET_CAP - 1)]);
		send_word(OP_INSERT, {$urandom, $urandom});
		send_word(OP_FIND, held_vals[SET_CAP - 1]);
		send_word(OP_REMOVE, {$urandom, $urandom});
		send_word(OP_UNUSED, VAL_MIN);
		wait_drained();
		repeat (40)
			send_word(OP_REMOVE, held_vals[$urandom_range(held_count - 1)]);
		wait_drained();
	endtask

	task automatic test_random_mix(input int tx_pct, input int rx_pct);
		int                        sel;
		logic [1:0]                op;
		logic signed [VALUE_W-1:0] val;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (80) begin
			sel = $urandom_range(99);
			if (sel < 30)
				op = OP_FIND;
			else if (sel < 65)
				op = OP_INSERT;
			else if (sel < 95)
				op = OP_REMOVE;
			else
				op = OP_UNUSED;
			// mostly a small pool and held values so hits are common
			sel = $urandom_range(99);
			if (sel < 55)
				val = value_pool[$urandom_range(POOL_SIZE - 1)];
			else if (sel < 80 && held_count > 0)
				val = held_vals[$urandom_range(held_count - 1)];
			else
				val = {$urandom, $urandom};
			send_word(op, val);
		end
		wait_drained();
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_stall   = 1'b0;
		hold_left   = 0;
		err_count   = 0;
		cycle_count = 0;
		held_count  = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 71;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = -64'sd1;
		value_pool[4] = 64'sd1;
		value_pool[5] = VAL_MIN + 64'sd1;
		value_pool[6] = VAL_MAX - 64'sd1;
		for (int i = 7; i < POOL_SIZE; i++)
			value_pool[i] = {$urandom, $urandom};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_store();
		test_extremes();
		test_fill_to_full();
		test_random_mix(10, 71);
		test_random_mix(71, 10);
		test_random_mix(0, 0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0 && rsp_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sis_pkg.sv
design/sis_cell.sv
design/sorted_integer_set_unit.sv
design/sisu_checker.sv
verif/tb_sorted_integer_set_unit.sv
